// ----- hdl/sfla_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared sizes, codes and state encoding for the segregated free-list
// allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int NUM_CLASSES       = 8;
  localparam int GRANULE_BYTES     = 8;
  localparam int HEAP_BYTES        = 4096;
  localparam int BLOCKS_PER_REFILL = 4;

  localparam int ADDR_W       = 12;
  localparam int SIZE_W       = 7;
  localparam int MAX_SIZE     = NUM_CLASSES * GRANULE_BYTES;
  localparam int NUM_GRANULES = HEAP_BYTES / GRANULE_BYTES;
  localparam int GRAN_SHIFT   = $clog2(GRANULE_BYTES);
  localparam int GRAN_W       = $clog2(NUM_GRANULES);
  localparam int LINK_W       = GRAN_W + 1;
  localparam int CLASS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W        = $clog2(HEAP_BYTES) + 1;
  localparam int CNT_W        = $clog2(BLOCKS_PER_REFILL);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_SIZE  = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_REFILL,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// ----- hdl/segregated_free_list_allocator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_core
// Eight-class LIFO free-list allocator with a bump-pointer refill; next links
// live in a single-port-write, registered-read link memory.
// ----------------------------------------------------------------------------
// An accepted request goes from EXEC to DONE for a free or any error, through READ for
// an allocate served from a list, or through REFILL for a refill; DONE then loads the
// output register. One item is in flight at a time: a new request is taken only in IDLE;
// a refill writes one link entry per cycle through the link memory write port.
// Reset empties every class list and returns the carve pointer to heap start;
// the link memory is not cleared, since only written entries are ever read.
module segregated_free_list_allocator_core
  import sfla_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              op_i,
  input  wire logic [SIZE_W-1:0] size_bytes_i,
  input  wire logic [ADDR_W-1:0] block_address_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ADDR_W-1:0]      address_o,
  output logic [1:0]             status_o
);

  state_e              state_q, state_d;
  op_e                 req_op_q, req_op_d;
  logic [SIZE_W-1:0]   req_size_q, req_size_d;
  logic [ADDR_W-1:0]   req_addr_q, req_addr_d;

  logic [GRAN_W-1:0]   head_q [NUM_CLASSES];
  logic [GRAN_W-1:0]   head_d [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] nonempty_q, nonempty_d;
  logic [PTR_W-1:0]    carve_q, carve_d;
  logic [PTR_W-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  status_e             out_status_q, out_status_d;

  logic [LINK_W-1:0]   link_mem [NUM_GRANULES];
  logic [LINK_W-1:0]   rdata_q;
  logic                mem_we;
  logic [GRAN_W-1:0]   mem_waddr;
  logic [LINK_W-1:0]   mem_wdata;
  logic [GRAN_W-1:0]   mem_raddr;

  logic                bad_size;
  logic [SIZE_W-1:0]   size_m1;
  logic [CLASS_W-1:0]  cls;
  logic [PTR_W-1:0]    rounded;
  logic [PTR_W-1:0]    need;
  logic [PTR_W-1:0]    remaining;
  logic [PTR_W-1:0]    carve_plus_r;
  logic [PTR_W-1:0]    cur_plus_r;
  logic [PTR_W-1:0]    free_end;
  logic                bad_addr;

  localparam logic [CNT_W-1:0] LastCnt = CNT_W'(BLOCKS_PER_REFILL - 1);

  // request decode
  assign bad_size     = (req_size_q == '0) || (req_size_q > SIZE_W'(MAX_SIZE));
  assign size_m1      = req_size_q - SIZE_W'(1);
  assign cls          = CLASS_W'(size_m1 >> GRAN_SHIFT);
  assign rounded      = (PTR_W'(cls) + PTR_W'(1)) << GRAN_SHIFT;
  assign need         = PTR_W'(rounded * PTR_W'(BLOCKS_PER_REFILL));
  assign remaining    = PTR_W'(HEAP_BYTES) - carve_q;
  assign carve_plus_r = carve_q + rounded;
  assign cur_plus_r   = cur_q + rounded;
  assign free_end     = PTR_W'(req_addr_q) + rounded;
  assign bad_addr     = (req_addr_q[GRAN_SHIFT-1:0] != '0) || (free_end > carve_q);
  assign mem_raddr    = head_q[cls];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign address_o   = out_addr_q;
  assign status_o    = out_status_q;

  always_comb begin
    state_d      = state_q;
    req_op_d     = req_op_q;
    req_size_d   = req_size_q;
    req_addr_d   = req_addr_q;
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    carve_d      = carve_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_op_d   = op_e'(op_i);
          req_size_d = size_bytes_i;
          req_addr_d = block_address_i;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        res_addr_d = '0;
        state_d    = S_DONE;
        if (bad_size) begin
          res_status_d = ST_BAD_SIZE;
        end else if (req_op_q == OP_FREE) begin
          if (bad_addr) begin
            res_status_d = ST_BAD_ADDR;
          end else begin
            // push onto the class list
            mem_we          = 1'b1;
            mem_waddr       = req_addr_q[ADDR_W-1:GRAN_SHIFT];
            mem_wdata       = nonempty_q[cls] ? {1'b1, head_q[cls]} : '0;
            head_d[cls]     = req_addr_q[ADDR_W-1:GRAN_SHIFT];
            nonempty_d[cls] = 1'b1;
            res_status_d    = ST_OK;
          end
        end else if (nonempty_q[cls]) begin
          // pop: link of the head arrives next cycle
          res_addr_d   = ADDR_W'({head_q[cls], {GRAN_SHIFT{1'b0}}});
          res_status_d = ST_OK;
          state_d      = S_READ;
        end else if (need > remaining) begin
          res_status_d = ST_EXHAUSTED;
        end else begin
          // carve a run of blocks, hand out the first, link the rest
          res_addr_d      = carve_q[ADDR_W-1:0];
          res_status_d    = ST_OK;
          head_d[cls]     = carve_plus_r[ADDR_W-1:GRAN_SHIFT];
          nonempty_d[cls] = 1'b1;
          carve_d         = carve_q + need;
          cur_d           = carve_plus_r;
          cnt_d           = CNT_W'(1);
          state_d         = S_REFILL;
        end
      end
      S_READ: begin
        if (rdata_q[LINK_W-1]) begin
          head_d[cls] = rdata_q[GRAN_W-1:0];
        end else begin
          head_d[cls]     = '0;
          nonempty_d[cls] = 1'b0;
        end
        state_d = S_DONE;
      end
      S_REFILL: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q[ADDR_W-1:GRAN_SHIFT];
        if (cnt_q == LastCnt) begin
          mem_wdata = '0;
          state_d   = S_DONE;
        end else begin
          mem_wdata = {1'b1, cur_plus_r[ADDR_W-1:GRAN_SHIFT]};
          cur_d     = cur_plus_r;
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      nonempty_q  <= '0;
      carve_q     <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nonempty_q  <= nonempty_d;
      carve_q     <= carve_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_op_q     <= req_op_d;
    req_size_q   <= req_size_d;
    req_addr_q   <= req_addr_d;
    cur_q        <= cur_d;
    cnt_q        <= cnt_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  // link memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= link_mem[mem_raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/sfla_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_checker
// Port-level checks for the allocator core, bound into every instance of the core.
// ----------------------------------------------------------------------------
module sfla_checker
  import sfla_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [ADDR_W-1:0] address_o,
  input wire logic [1:0]        status_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(address_o) && $stable(status_o))
    else $error("result changed while stalled");

  // errors carry a zero address
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> address_o == '0)
    else $error("nonzero address on error");

  // handed-out blocks are granule aligned
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> address_o[GRAN_SHIFT-1:0] == '0)
    else $error("misaligned block address");

  // one item in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

endmodule

bind segregated_free_list_allocator_core sfla_checker u_sfla_checker (.*);
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segregated free-list allocator core. A local
// model of the class lists, link memory and bump pointer predicts the
// address and status of every accepted request. Stimulus runs a short
// directed pass, then random alloc/free traffic built from live blocks, with
// random idling on both sides, a long output stall and heap exhaustion.
// ----------------------------------------------------------------------------
module tb_top;
  import sfla_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_e           status;
  } alloc_result_t;

  typedef struct {
    int addr;
    int size;
  } live_block_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              op_i;
  logic [SIZE_W-1:0] size_bytes_i;
  logic [ADDR_W-1:0] block_address_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ADDR_W-1:0] address_o;
  logic [1:0]        status_o;

  // Allocator model state
  logic [GRAN_W-1:0] list_head [NUM_CLASSES];
  logic              list_full [NUM_CLASSES];
  logic [LINK_W-1:0] link_mem  [NUM_GRANULES];
  logic [PTR_W-1:0]  bump_ptr;

  alloc_result_t pending_results [$];
  live_block_t   live_blocks [$];
  live_block_t   recent_frees [$];

  int tx_gap_pct;
  int rx_stall_pct;
  int rx_hold_left;
  int rx_stall_left;
  int rx_gap;
  int mismatch_count;
  int results_checked;
  int requests_sent;
  int status_seen [4];
  int quiet_cycles;

  segregated_free_list_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .size_bytes_i    (size_bytes_i),
    .block_address_i (block_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .address_o       (address_o),
    .status_o        (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic alloc_result_t predict_allocator(op_e op, logic [SIZE_W-1:0] size,
                                                      logic [ADDR_W-1:0] baddr);
    alloc_result_t res;
    int cls;
    int rounded;
    int need;
    int base;
    int gran;
    int addr;
    res.address = '0;
    res.status  = ST_OK;
    if (size == 0 || int'(size) > MAX_SIZE) begin
      res.status = ST_BAD_SIZE;
      return res;
    end
    cls     = (int'(size) + GRANULE_BYTES - 1) / GRANULE_BYTES - 1;
    rounded = (cls + 1) * GRANULE_BYTES;
    base    = int'(bump_ptr);
    if (op == OP_FREE) begin
      addr = int'(baddr);
      if (addr % GRANULE_BYTES != 0 || addr >= base || rounded > base - addr) begin
        res.status = ST_BAD_ADDR;
      end else begin
        gran = addr / GRANULE_BYTES;
        link_mem[gran]  = list_full[cls] ? {1'b1, list_head[cls]} : '0;
        list_head[cls]  = GRAN_W'(gran);
        list_full[cls]  = 1'b1;
      end
    end else if (list_full[cls]) begin
      gran = int'(list_head[cls]);
      res.address = ADDR_W'(gran * GRANULE_BYTES);
      if (link_mem[gran][GRAN_W]) begin
        list_head[cls] = link_mem[gran][GRAN_W-1:0];
      end else begin
        list_head[cls] = '0;
        list_full[cls] = 1'b0;
      end
    end else begin
      need = rounded * BLOCKS_PER_REFILL;
      if (need > HEAP_BYTES - base) begin
        res.status = ST_EXHAUSTED;
      end else begin
        // link the carved blocks in address order; the first one goes out
        for (int i = 1; i < BLOCKS_PER_REFILL; i++) begin
          gran = ((base + i * rounded) / GRANULE_BYTES) % NUM_GRANULES;
          if (i + 1 < BLOCKS_PER_REFILL)
            link_mem[gran] = {1'b1, GRAN_W'((base + (i + 1) * rounded) / GRANULE_BYTES)};
          else
            link_mem[gran] = '0;
        end
        list_head[cls] = GRAN_W'((base + rounded) / GRANULE_BYTES);
        list_full[cls] = 1'b1;
        bump_ptr       = PTR_W'(base + need);
        res.address    = ADDR_W'(base);
      end
    end
    return res;
  endfunction

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int bad_size();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_SIZE + 1, (1 << SIZE_W) - 1);
  endfunction

  function automatic void remember_free(live_block_t blk);
    recent_frees.push_back(blk);
    if (recent_frees.size() > 8) void'(recent_frees.pop_front());
  endfunction

  function automatic void note_mismatch(string what);
    if (mismatch_count < 10) $display("mismatch: %s", what);
    mismatch_count++;
  endfunction

  task automatic send_request(input op_e op, input int size, input int baddr,
                              output alloc_result_t predicted);
    int gap;
    gap = pick_gap(tx_gap_pct);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    op_i            <= op;
    size_bytes_i    <= SIZE_W'(size);
    block_address_i <= ADDR_W'(baddr);
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = predict_allocator(op, SIZE_W'(size), ADDR_W'(baddr));
    pending_results.push_back(predicted);
    requests_sent++;
    status_seen[predicted.status]++;
    if (op == OP_ALLOC && predicted.status == ST_OK)
      live_blocks.push_back('{addr: int'(predicted.address), size: size});
  endtask

  // Drop valid and hold the sender until every result is back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_traffic(input int count, input int alloc_pct, input int noise_pct);
    alloc_result_t res;
    live_block_t   blk;
    int            pick;
    int            idx;
    int            cls;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
        case ($urandom_range(0, 4))
          0: send_request(OP_ALLOC, bad_size(), $urandom, res);
          1: send_request(OP_FREE, bad_size(), $urandom, res);
          2: send_request(OP_FREE, $urandom_range(1, MAX_SIZE),
                          $urandom_range(0, NUM_GRANULES - 1) * GRANULE_BYTES +
                          (($urandom_range(0, 3) == 0) ? $urandom_range(1, GRANULE_BYTES - 1) : 0),
                          res);
          3: begin
            // free a live block under an arbitrary class
            if (live_blocks.size() != 0) begin
              idx = $urandom_range(0, live_blocks.size() - 1);
              blk = live_blocks[idx];
              live_blocks.delete(idx);
              send_request(OP_FREE, $urandom_range(1, MAX_SIZE), blk.addr, res);
              remember_free(blk);
            end else begin
              send_request(OP_ALLOC, $urandom_range(1, MAX_SIZE), $urandom, res);
            end
          end
          default: begin
            // free again something that was already returned
            if (recent_frees.size() != 0) begin
              blk = recent_frees[$urandom_range(0, recent_frees.size() - 1)];
              send_request(OP_FREE, blk.size, blk.addr, res);
            end else begin
              send_request(OP_FREE, $urandom_range(1, MAX_SIZE), $urandom, res);
            end
          end
        endcase
      end else if (pick < noise_pct + alloc_pct || live_blocks.size() == 0) begin
        send_request(OP_ALLOC, $urandom_range(1, MAX_SIZE), $urandom, res);
      end else begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        cls = (blk.size + GRANULE_BYTES - 1) / GRANULE_BYTES - 1;
        send_request(OP_FREE, cls * GRANULE_BYTES + $urandom_range(1, GRANULE_BYTES),
                     blk.addr, res);
        remember_free(blk);
      end
    end
  endtask

  task automatic test_directed_cases();
    alloc_result_t res;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    send_request(OP_ALLOC, 0, 0, res);            // zero size
    send_request(OP_FREE, 0, 0, res);
    send_request(OP_ALLOC, MAX_SIZE + 1, 0, res); // just past the largest class
    send_request(OP_FREE, 127, 4095, res);
    send_request(OP_FREE, 8, 0, res);             // nothing carved yet
    send_request(OP_ALLOC, 1, 4095, res);         // refill of the smallest class
    send_request(OP_ALLOC, 8, 0, res);            // served from the list
    send_request(OP_ALLOC, MAX_SIZE, 0, res);     // refill of the largest class
    send_request(OP_FREE, 8, 3, res);             // misaligned
    send_request(OP_FREE, 8, 0, res);
    send_request(OP_FREE, 16, 280, res);          // block runs past the carve point
    send_request(OP_FREE, MAX_SIZE, 4088, res);   // above the carve point
    send_request(OP_FREE, MAX_SIZE, 4095, res);
    send_request(OP_ALLOC, 1, 0, res);
    send_request(OP_ALLOC, 57, 0, res);
    send_request(OP_FREE, MAX_SIZE, 32, res);
    send_request(OP_ALLOC, MAX_SIZE, 0, res);
    send_request(OP_FREE, 24, 8, res);            // pushed onto another class
    send_request(OP_ALLOC, 17, 0, res);
    send_request(OP_FREE, 8, 0, res);
    send_request(OP_FREE, 8, 0, res);             // same block twice
    send_request(OP_ALLOC, 8, 0, res);
    send_request(OP_ALLOC, 8, 0, res);
    send_request(OP_ALLOC, 40, 0, res);
    send_request(OP_FREE, MAX_SIZE, 384, res);    // ends exactly at the carve point
    drain_results();
  endtask

  task automatic test_mixed_traffic();
    tx_gap_pct   = 25;
    rx_stall_pct = 25;
    run_random_traffic(450, 50, 15);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rx_hold_left = 80;
    run_random_traffic(24, 50, 10);
    drain_results();
  endtask

  task automatic test_heap_exhaustion();
    alloc_result_t res;
    int n;
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    n = 0;
    do begin
      send_request(OP_ALLOC, MAX_SIZE, $urandom, res);
      n++;
    end while (res.status != ST_EXHAUSTED && n < 200);
    send_request(OP_ALLOC, $urandom_range(1, MAX_SIZE), $urandom, res);
    drain_results();
  endtask

  task automatic test_back_to_back();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    run_random_traffic(350, 45, 10);
    drain_results();
  endtask

  task automatic test_free_churn();
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    run_random_traffic(450, 40, 20);
    drain_results();
  endtask

  // Receiver: long hold-off first, then random stalls.
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_ready_i <= 1'b0;
      rx_stall_left--;
    end else begin
      rx_gap = pick_gap(rx_stall_pct);
      if (rx_gap > 0) begin
        out_ready_i   <= 1'b0;
        rx_stall_left = rx_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    alloc_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result address=%0d status=%0d",
                                address_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (address_o !== want.address || status_o !== want.status)
          note_mismatch($sformatf("address exp %0d got %0d, status exp %0d got %0d",
                                  want.address, address_o, want.status, status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    in_valid_i      = 1'b0;
    op_i            = OP_ALLOC;
    size_bytes_i    = '0;
    block_address_i = '0;
    tx_gap_pct      = 0;
    rx_stall_pct    = 0;
    rx_hold_left    = 0;
    rx_stall_left   = 0;
    mismatch_count  = 0;
    results_checked = 0;
    requests_sent   = 0;
    quiet_cycles    = 0;
    status_seen     = '{default: 0};
    for (int c = 0; c < NUM_CLASSES; c++) begin
      list_head[c] = '0;
      list_full[c] = 1'b0;
    end
    for (int g = 0; g < NUM_GRANULES; g++) link_mem[g] = '0;
    bump_ptr = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_mixed_traffic();
    test_output_backpressure();
    test_heap_exhaustion();
    test_back_to_back();
    test_free_churn();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Ran %0d requests: %0d ok, %0d heap exhausted, %0d bad size, %0d bad address",
             requests_sent, status_seen[ST_OK], status_seen[ST_EXHAUSTED],
             status_seen[ST_BAD_SIZE], status_seen[ST_BAD_ADDR]);
    $display("Checked %0d results with %0d mismatches, %0d blocks still live",
             results_checked, mismatch_count, live_blocks.size());
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
